@@ design/rdb_pkg.sv @@
// Shared constants, types and codes for the request dispatch balancer.
// Used by rdb_ctrl, rdb_datapath and request_dispatch_balancer_core.
`default_nettype none

package rdb_pkg;

    localparam int SERVERS     = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int SLOT_W     = 4;
    localparam int NUM_SLOTS  = 1 << SLOT_W;
    localparam int SLOT_LIMIT = (SERVERS < NUM_SLOTS) ? SERVERS : NUM_SLOTS;
    localparam int NSRV_W     = 5;
    localparam int CONN_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 5;
    localparam int GROUPS     = 4;
    localparam int GROUP_SIZE = NUM_SLOTS / GROUPS;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SERVERS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POLICY         = CFG_IDX_W'(1);

    localparam logic FUNC_ROUTE    = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    localparam logic POLICY_RR = 1'b0;
    localparam logic POLICY_LC = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ROUTED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic                   ok;
        logic [SLOT_W-1:0]      idx;
        logic [COUNT_WIDTH-1:0] val;
    } t_cand;

    function automatic t_cand pick_min(input t_cand a, input t_cand b);
        if (b.ok && (!a.ok || (b.val < a.val))) begin
            return b;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

@@ design/rdb_ctrl.sv @@
// Controller state machine for the request dispatch balancer.
// Depends on rdb_pkg; drives the command struct of rdb_datapath.
`default_nettype none

module rdb_ctrl
    import rdb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output t_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state == S_EXEC);
    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.exec    = (r_state == S_EXEC);

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("Controller stayed busy for more than one cycle.");

    a_exec_follows_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("An accepted beat was not executed in the next cycle.");

    a_no_capture_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !o_cmd.capture)
        else $error("Capture was issued while an item was executing.");

endmodule

`default_nettype wire

@@ design/rdb_datapath.sv @@
// Datapath of the request dispatch balancer: configuration registers, connection
// counters, round-robin pointer, registered minimum tree and result registers.
// Depends on rdb_pkg; commanded by rdb_ctrl.
`default_nettype none

module rdb_datapath
    import rdb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_func,
    input  wire logic [SLOT_W-1:0]     i_server_slot,
    output logic                       o_done,
    output logic [SLOT_W-1:0]          o_chosen_slot,
    output logic [CONN_W-1:0]          o_connections,
    output logic [STATUS_W-1:0]        o_status
);

    logic [NSRV_W-1:0]      r_active_servers;
    logic                   r_policy;
    logic [COUNT_WIDTH-1:0] r_count [NUM_SLOTS];
    logic [SLOT_W-1:0]      r_rr_ptr;
    logic                   r_func;
    logic [SLOT_W-1:0]      r_slot_in;
    t_cand                  r_cand [GROUPS];
    logic                   r_done;
    logic [SLOT_W-1:0]      r_chosen;
    logic [CONN_W-1:0]      r_conn;
    logic [STATUS_W-1:0]    r_status;

    logic [NSRV_W-1:0]      n_in_use;
    t_cand                  n_cand [GROUPS];
    t_cand                  lc_lo;
    t_cand                  lc_hi;
    t_cand                  lc_best;
    logic [SLOT_W-1:0]      rr_slot;
    logic [NSRV_W-1:0]      rr_inc;
    logic [SLOT_W-1:0]      n_rr_ptr;
    logic [SLOT_W-1:0]      sel_slot;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   cnt_we;
    logic [STATUS_W-1:0]    n_status;
    logic [COUNT_WIDTH-1:0] res_count;

    always_comb begin
        if (r_active_servers == '0) begin
            n_in_use = NSRV_W'(1);
        end else if (r_active_servers > NSRV_W'(SLOT_LIMIT)) begin
            n_in_use = NSRV_W'(SLOT_LIMIT);
        end else begin
            n_in_use = r_active_servers;
        end
    end

    always_comb begin
        t_cand leaf [GROUP_SIZE];
        t_cand pair [GROUP_SIZE/2];
        for (int g = 0; g < GROUPS; g++) begin
            for (int k = 0; k < GROUP_SIZE; k++) begin
                leaf[k].idx = SLOT_W'(g * GROUP_SIZE + k);
                leaf[k].val = r_count[g * GROUP_SIZE + k];
                leaf[k].ok  = ({1'b0, leaf[k].idx} < n_in_use);
            end
            for (int p = 0; p < GROUP_SIZE / 2; p++) begin
                pair[p] = pick_min(leaf[2*p], leaf[2*p+1]);
            end
            n_cand[g] = pick_min(pair[0], pair[1]);
        end
    end

    assign lc_lo   = pick_min(r_cand[0], r_cand[1]);
    assign lc_hi   = pick_min(r_cand[2], r_cand[3]);
    assign lc_best = pick_min(lc_lo, lc_hi);

    assign rr_slot  = ({1'b0, r_rr_ptr} < n_in_use) ? r_rr_ptr : '0;
    assign rr_inc   = {1'b0, rr_slot} + NSRV_W'(1);
    assign n_rr_ptr = (rr_inc == n_in_use) ? '0 : rr_inc[SLOT_W-1:0];

    always_comb begin
        if (r_func == FUNC_ROUTE) begin
            sel_slot = (r_policy == POLICY_LC) ? lc_best.idx : rr_slot;
        end else begin
            sel_slot = r_slot_in;
        end
        cur       = r_count[sel_slot];
        n_count   = cur;
        cnt_we    = 1'b0;
        res_count = '0;
        if (r_func == FUNC_ROUTE) begin
            if (cur == COUNT_MAX) begin
                n_status = STATUS_SATURATED;
            end else begin
                n_count  = cur + COUNT_WIDTH'(1);
                cnt_we   = 1'b1;
                n_status = STATUS_ROUTED;
            end
            res_count = n_count;
        end else if (({1'b0, r_slot_in} >= n_in_use) || (cur == '0)) begin
            n_status = STATUS_IGNORED;
        end else begin
            n_count   = cur - COUNT_WIDTH'(1);
            cnt_we    = 1'b1;
            n_status  = STATUS_COMPLETED;
            res_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_servers <= NSRV_W'(1);
            r_policy         <= POLICY_RR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ACTIVE_SERVERS: r_active_servers <= i_cfg_data;
                REG_POLICY:         r_policy         <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_count[i] <= '0;
            end
            r_rr_ptr <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec && cnt_we) begin
                r_count[sel_slot] <= n_count;
            end
            if (i_cmd.exec && (r_func == FUNC_ROUTE) && (r_policy == POLICY_RR)) begin
                r_rr_ptr <= n_rr_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_func;
            r_slot_in <= i_server_slot;
            for (int g = 0; g < GROUPS; g++) begin
                r_cand[g] <= n_cand[g];
            end
        end
        if (i_cmd.exec) begin
            r_chosen <= sel_slot;
            r_conn   <= CONN_W'(res_count);
            r_status <= n_status;
        end
    end

    assign o_done        = r_done;
    assign o_chosen_slot = r_chosen;
    assign o_connections = r_conn;
    assign o_status      = r_status;

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_cmd.exec))
        else $error("A result beat appeared without an executed item.");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STATUS_IGNORED)) |-> (o_connections == '0))
        else $error("An ignored completion reported a nonzero count.");

    a_ptr_moves_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_rr_ptr))
        else $error("Round-robin pointer moved outside an executed route.");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_func == FUNC_ROUTE)) |-> ({1'b0, sel_slot} < n_in_use))
        else $error("A route selected a slot that is not in use.");

endmodule

`default_nettype wire

@@ design/request_dispatch_balancer_core.sv @@
// Request dispatch balancer: an item is taken when start is high and busy is low.
// Busy is high for the following cycle, and the result beat is shown on o_done and
// the result ports in the cycle after that; the next item may be started in that
// same cycle, but no new item is taken while one is executing. On capture a
// four-way partial minimum over the connection counters is registered; the execute
// step finishes the minimum and updates the counter.
// The result cannot be held off. Configuration writes are always ready and are
// to be made only while the block is idle. Depends on rdb_pkg, rdb_ctrl, rdb_datapath.
`default_nettype none

module request_dispatch_balancer_core
    import rdb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_func,
    input  wire logic [SLOT_W-1:0]     i_server_slot,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_done,
    output logic [SLOT_W-1:0]          o_chosen_slot,
    output logic [CONN_W-1:0]          o_connections,
    output logic [STATUS_W-1:0]        o_status
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    rdb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    rdb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_server_slot (i_server_slot),
        .o_done        (o_done),
        .o_chosen_slot (o_chosen_slot),
        .o_connections (o_connections),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire
